/* design/srs_pkg.sv */
package srs_pkg;

    localparam int MaxPat   = 16;
    localparam int CharW    = 8;
    localparam int CntW     = $clog2(MaxPat);
    localparam int LenW     = $clog2(MaxPat + 1);
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 64;
    localparam int BankW    = 2 * CfgDataW;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_PAT_LEN = 3'd0,
        CFG_PAT_LO  = 3'd1,
        CFG_PAT_HI  = 3'd2,
        CFG_REP_LEN = 3'd3,
        CFG_REP_LO  = 3'd4,
        CFG_REP_HI  = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_OLDEST,
        EMIT_REP,
        EMIT_FLUSH,
        EMIT_CLOSE
    } t_emit;

    typedef struct packed {
        logic  accept;
        t_emit emit;
        logic  str_end;
    } t_srs_cmd;

    typedef struct packed {
        logic out_free;
        logic ins_full;
        logic ins_match;
        logic rep_zero;
        logic rep_last;
        logic plen_one;
        logic flush_last;
    } t_srs_stat;

endpackage

/* design/srs_dp.sv */
module srs_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [srs_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [srs_pkg::CfgDataW-1:0]   i_cfg_data,
    input  logic [srs_pkg::CharW-1:0]      i_char,
    input  srs_pkg::t_srs_cmd              i_cmd,
    output srs_pkg::t_srs_stat             o_stat,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic [srs_pkg::CharW-1:0]      o_out_char,
    output logic                           o_char_valid,
    output logic                           o_string_end
);
    import srs_pkg::*;

    logic [CharW-1:0] r_win [MaxPat];
    logic [CharW-1:0] n_win [MaxPat];
    logic [CharW-1:0] ins_win [MaxPat];
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic [CntW-1:0]  r_ridx, n_ridx;
    logic [LenW-1:0]  r_plen, r_rlen;
    logic [BankW-1:0] r_pat, r_rep;
    logic             r_out_valid, n_out_valid;
    logic [CharW-1:0] r_out_char, n_out_char;
    logic             r_out_cv, n_out_cv;
    logic             r_out_end, n_out_end;
    logic [LenW-1:0]  cnt_inc;
    logic [LenW-1:0]  cfg_len;
    logic             match;
    logic             out_free;

    assign cfg_len  = i_cfg_data[LenW-1:0];
    assign cnt_inc  = LenW'(r_cnt) + LenW'(1);
    assign out_free = !r_out_valid || !i_out_stall;

    // window with the new byte placed behind the held ones
    always_comb begin
        for (int i = 0; i < MaxPat; i++) begin
            ins_win[i] = (CntW'(i) == r_cnt) ? i_char : r_win[i];
        end
        match = 1'b1;
        for (int i = 0; i < MaxPat; i++) begin
            if (LenW'(i) < r_plen && ins_win[i] != r_pat[i*CharW +: CharW]) begin
                match = 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.out_free   = out_free;
        o_stat.ins_full   = (cnt_inc == r_plen);
        o_stat.ins_match  = match;
        o_stat.rep_zero   = (r_rlen == '0);
        o_stat.rep_last   = ((LenW'(r_ridx) + LenW'(1)) == r_rlen);
        o_stat.plen_one   = (r_plen == LenW'(1));
        o_stat.flush_last = (r_cnt == CntW'(1));
    end

    always_comb begin
        n_win       = r_win;
        n_cnt       = r_cnt;
        n_ridx      = r_ridx;
        n_out_valid = r_out_valid && !out_free;
        n_out_char  = r_out_char;
        n_out_cv    = r_out_cv;
        n_out_end   = r_out_end;

        if (i_cmd.accept) begin
            n_win = ins_win;
            if (cnt_inc == r_plen) begin
                if (match) begin
                    n_cnt  = '0;
                    n_ridx = '0;
                end else begin
                    for (int i = 0; i < MaxPat - 1; i++) begin
                        n_win[i] = ins_win[i+1];
                    end
                    n_cnt = CntW'(r_plen - LenW'(1));
                end
            end else begin
                n_cnt = cnt_inc[CntW-1:0];
            end
        end

        case (i_cmd.emit)
            EMIT_OLDEST: begin
                n_out_char = ins_win[0];
                n_out_cv   = 1'b1;
            end
            EMIT_REP: begin
                n_out_char = r_rep[r_ridx*CharW +: CharW];
                n_out_cv   = 1'b1;
                n_ridx     = r_ridx + CntW'(1);
            end
            EMIT_FLUSH: begin
                n_out_char = r_win[0];
                n_out_cv   = 1'b1;
                for (int i = 0; i < MaxPat - 1; i++) begin
                    n_win[i] = r_win[i+1];
                end
                n_cnt = r_cnt - CntW'(1);
            end
            EMIT_CLOSE: begin
                n_out_char = '0;
                n_out_cv   = 1'b0;
            end
            default: ;
        endcase
        if (i_cmd.emit != EMIT_NONE) begin
            n_out_valid = 1'b1;
            n_out_end   = i_cmd.str_end;
        end

        // a new pattern length drops whatever the window holds
        if (i_cfg_we && i_cfg_index == CFG_PAT_LEN) begin
            n_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win      <= n_win;
        r_ridx     <= n_ridx;
        r_out_char <= n_out_char;
        r_out_cv   <= n_out_cv;
        r_out_end  <= n_out_end;
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen <= LenW'(1);
            r_rlen <= '0;
            r_pat  <= '0;
            r_rep  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PAT_LEN: begin
                    if (cfg_len == '0) begin
                        r_plen <= LenW'(1);
                    end else if (cfg_len > LenW'(MaxPat)) begin
                        r_plen <= LenW'(MaxPat);
                    end else begin
                        r_plen <= cfg_len;
                    end
                end
                CFG_PAT_LO: r_pat[CfgDataW-1:0]     <= i_cfg_data;
                CFG_PAT_HI: r_pat[BankW-1:CfgDataW] <= i_cfg_data;
                CFG_REP_LEN: begin
                    if (cfg_len > LenW'(MaxPat)) begin
                        r_rlen <= LenW'(MaxPat);
                    end else begin
                        r_rlen <= cfg_len;
                    end
                end
                CFG_REP_LO: r_rep[CfgDataW-1:0]     <= i_cfg_data;
                CFG_REP_HI: r_rep[BankW-1:CfgDataW] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_char   = r_out_char;
    assign o_char_valid = r_out_cv;
    assign o_string_end = r_out_end;

endmodule

/* design/srs_ctrl.sv */
module srs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_final_char,
    input  srs_pkg::t_srs_stat i_stat,
    output logic               o_in_stall,
    output srs_pkg::t_srs_cmd  o_cmd
);
    import srs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REP,
        S_FLUSH
    } t_state;

    t_state r_state, n_state;
    logic   r_last, n_last;
    logic   in_ready;

    assign in_ready   = (r_state == S_IDLE) && i_stat.out_free;
    assign o_in_stall = !in_ready;

    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        o_cmd   = '{accept: 1'b0, emit: EMIT_NONE, str_end: 1'b0};
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && in_ready) begin
                    o_cmd.accept = 1'b1;
                    n_last       = i_final_char;
                    if (i_stat.ins_full) begin
                        if (i_stat.ins_match) begin
                            if (!i_stat.rep_zero) begin
                                n_state = S_REP;
                            end else if (i_final_char) begin
                                o_cmd.emit    = EMIT_CLOSE;
                                o_cmd.str_end = 1'b1;
                            end
                        end else begin
                            o_cmd.emit    = EMIT_OLDEST;
                            o_cmd.str_end = i_final_char && i_stat.plen_one;
                            if (i_final_char && !i_stat.plen_one) begin
                                n_state = S_FLUSH;
                            end
                        end
                    end else if (i_final_char) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_REP: begin
                if (i_stat.out_free) begin
                    o_cmd.emit    = EMIT_REP;
                    o_cmd.str_end = r_last && i_stat.rep_last;
                    if (i_stat.rep_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FLUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.emit    = EMIT_FLUSH;
                    o_cmd.str_end = i_stat.flush_last;
                    if (i_stat.flush_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

endmodule

/* design/substring_replace_stream.sv */
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_stall    i_in_char, i_final_char
// out       output     o_out_valid / i_out_stall  o_out_char, o_char_valid, o_string_end
// cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// one input beat per cycle, while the output register is free, as bytes pass
// through or only fill the window; a match with a nonempty replacement holds
// input while the replacement bytes go out, the end-of-string flush while the
// bytes left in the window go out; the single output register paces both runs
// synchronous active-low reset empties the window and the output register
// output stall backs up through the output register into o_in_stall
module substring_replace_stream (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [srs_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [srs_pkg::CfgDataW-1:0]   i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [srs_pkg::CharW-1:0]      i_in_char,
    input  logic                           i_final_char,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [srs_pkg::CharW-1:0]      o_out_char,
    output logic                           o_char_valid,
    output logic                           o_string_end
);
    import srs_pkg::*;

    t_srs_cmd  cmd;
    t_srs_stat stat;

    srs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_final_char (i_final_char),
        .i_stat       (stat),
        .o_in_stall   (o_in_stall),
        .o_cmd        (cmd)
    );

    srs_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_char       (i_in_char),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_char   (o_out_char),
        .o_char_valid (o_char_valid),
        .o_string_end (o_string_end)
    );

endmodule
